// ----- design/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg
// Shared widths, action and status codes for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    // payload field widths
    localparam int ACTION_W    = 3;
    localparam int POS_W       = 8;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int STATUS_W    = 2;

    // default list depth
    localparam int DEFAULT_CAPACITY = 64;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_READ   = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    // value returned by a read of an empty list
    localparam logic [VALUE_W-1:0] EMPTY_READ_VALUE = '1;

endpackage

// ----- design/ils_req_if.sv -----
// ----------------------------------------------------------------------------
// ils_req_if
// Request channel of the indexed list store: one action word per handshake.
// ----------------------------------------------------------------------------
interface ils_req_if
    import ils_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic signed [POS_W-1:0]   position;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, output action, output position, output item_value,
                    input ready);
    modport sink   (input valid, input action, input position, input item_value,
                    output ready);
endinterface

// ----- design/ils_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ils_rsp_if
// Response channel of the indexed list store: one result word per action.
// ----------------------------------------------------------------------------
interface ils_rsp_if
    import ils_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [VALUE_W-1:0]   read_value;
    logic [COUNT_OUT_W-1:0]      entry_count;
    logic                        list_empty;
    logic [STATUS_W-1:0]         status;

    modport source (output valid, output read_value, output entry_count,
                    output list_empty, output status, input ready);
    modport sink   (input valid, input read_value, input entry_count,
                    input list_empty, input status, output ready);
endinterface

// ----- design/ils_ram.sv -----
// ----------------------------------------------------------------------------
// ils_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit entries held in one RAM, with append,
// remove at position, read, write and clear actions.
// ----------------------------------------------------------------------------
//  channel | dir | word                                     | accepted when
//  --------+-----+------------------------------------------+---------------
//  req     | in  | action, position, item_value             | valid && ready
//  rsp     | out | read_value, entry_count, list_empty, sts | valid && ready
//
//  append, read, write, clear, ignored remove: accept, then result load.
//  remove in range: accept, shift (none for the last entry), result load;
//  the shift moves one entry per cycle through the RAM (one read and one
//  write port, registered read).
//  reset clears the entry count, state and output valid; RAM contents are not touched.
//  a stalled rsp holds the finished result; req is taken again once it loads.
// ----------------------------------------------------------------------------
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W - 1) ? CW : POS_W - 1) + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [VALUE_W-1:0]   res_value_reg, res_value_next;
    status_t              res_status_reg, res_status_next;
    logic                 res_use_rd_reg, res_use_rd_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic                 out_empty_reg, out_empty_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    // ram ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;

    // position decode
    logic                 accept;
    logic                 pos_neg;
    logic [XW-1:0]        pos_x;
    logic [XW-1:0]        cnt_x;
    logic                 pos_lt_n;
    logic                 shift_needed;
    logic                 list_full;
    logic                 slot_free;
    logic [XW-1:0]        idx_x;

    ils_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and compares
    assign req.ready    = (state_reg == S_IDLE);
    assign accept       = req.valid && req.ready;
    assign slot_free    = !out_valid_reg || rsp.ready;
    assign pos_neg      = req.position[POS_W-1];
    assign pos_x        = XW'(req.position[POS_W-2:0]);
    assign cnt_x        = XW'(count_reg);
    assign idx_x        = XW'(idx_reg);
    assign pos_lt_n     = !pos_neg && (pos_x < cnt_x);
    assign shift_needed = (pos_x + XW'(2)) <= cnt_x;
    assign list_full    = (count_reg >= CW'(CAPACITY));

    // action decode, shift sequencer and result load
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_use_rd_next = res_use_rd_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = AW'(idx_x + XW'(2));

        // result word taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_status_next = ST_DONE;
                    res_use_rd_next = 1'b0;
                    state_next      = S_RESP;
                    unique case (req.action)
                        ACT_APPEND:
                        begin
                            if (list_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = req.item_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (pos_lt_n)
                            begin
                                count_next = count_reg - CW'(1);
                                if (shift_needed)
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = AW'(pos_x + XW'(1));
                                    idx_next   = AW'(pos_x);
                                    state_next = S_SHIFT;
                                end
                            end
                            else
                            begin
                                res_status_next = ST_IGNORED;
                            end
                        end
                        ACT_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_value_next  = EMPTY_READ_VALUE;
                                res_status_next = ST_IGNORED;
                            end
                            else
                            begin
                                ram_re          = 1'b1;
                                res_use_rd_next = 1'b1;
                                if (pos_neg)
                                begin
                                    ram_raddr = '0;
                                end
                                else if (pos_lt_n)
                                begin
                                    ram_raddr = AW'(pos_x);
                                end
                                else
                                begin
                                    ram_raddr = AW'(count_reg - CW'(1));
                                end
                            end
                        end
                        ACT_WRITE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_IGNORED;
                            end
                            else if (pos_neg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = req.item_value;
                            end
                            else if (pos_lt_n)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(pos_x);
                                ram_wdata = req.item_value;
                            end
                            else
                            begin
                                res_status_next = ST_IGNORED;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            res_status_next = ST_IGNORED;
                        end
                    endcase
                end
            end

            // move entry idx+1 down to idx, fetch the next one
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if ((idx_x + XW'(1)) < cnt_x)
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            // load the result word once the output slot is free
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_use_rd_reg ? ram_rdata : res_value_reg;
                    out_count_next  = COUNT_OUT_W'(count_reg);
                    out_empty_next  = (count_reg == '0);
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_use_rd_reg <= res_use_rd_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
        out_status_reg <= out_status_next;
    end

    // response drive
    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.list_empty  = out_empty_reg;
    assign rsp.status      = out_status_reg;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // the shift never reads and writes the same entry in one cycle
    a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram read and write collide");

    // shift writes stay inside the shrunken list
    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_x < cnt_x))
        else $error("shift index past entry count");

    // every accepted word is followed by work or a pending result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SHIFT || state_reg == S_RESP))
        else $error("accepted word dropped");

    // a result loads only into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && !slot_free) |=> (state_reg == S_RESP))
        else $error("result loaded over a pending word");

endmodule

// ----- verif/tb_indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_list_store
// Self-checking testbench for the indexed list store. A short table of
// directed actions covers the empty list, the value extremes, clamped and
// ignored positions, the unused action codes and clear. A long random run
// follows in fill, drain and mixed phases. Every result word is compared
// with a shadow copy of the list kept in the testbench. Both channels idle
// at random, the response side once holds off long enough to back up the
// request side, and the sender once waits for the list store to drain.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;
    import ils_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH     = DEFAULT_CAPACITY;
    localparam int TOTAL_WORDS    = 1900;
    localparam int HOLDOFF_AT     = 700;
    localparam int DRAIN_AT       = 1300;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 2 * LIST_DEPTH + 16;
    localparam int QUIET_LIMIT    = 5000;
    localparam int REPORT_LIMIT   = 10;

    // action codes with no defined action
    localparam logic [ACTION_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_MID   = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD_LAST  = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      list_empty;
        logic [STATUS_W-1:0]       status;
    } list_result_t;

    // one request word; fixed holds a hand-written result when pinned is set
    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [POS_W-1:0]   position;
        logic signed [VALUE_W-1:0] item_value;
        logic                      pinned;
        list_result_t              fixed;
    } list_cmd_t;

    typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} traffic_phase_t;

    // directed actions, walked in order right after reset
    localparam int NUM_DIRECTED = 26;
    localparam list_cmd_t DIRECTED_CMDS [NUM_DIRECTED] = '{
        '{ACT_READ,   8'sd0,   32'sd0,        1'b1, '{EMPTY_READ_VALUE, 7'd0, 1'b1, ST_IGNORED}},
        '{ACT_REMOVE, 8'sd0,   32'sd0,        1'b1, '{32'sd0,   7'd0, 1'b1, ST_IGNORED}},
        '{ACT_WRITE,  -8'sd1,  32'sd7,        1'b1, '{32'sd0,   7'd0, 1'b1, ST_IGNORED}},
        '{ACT_CLEAR,  8'sd0,   32'sd0,        1'b1, '{32'sd0,   7'd0, 1'b1, ST_DONE}},
        '{ACT_RSVD_FIRST, 8'sd3, 32'sd9,      1'b1, '{32'sd0,   7'd0, 1'b1, ST_IGNORED}},
        '{ACT_APPEND, 8'sd0,   VALUE_MAX,     1'b1, '{32'sd0,   7'd1, 1'b0, ST_DONE}},
        '{ACT_APPEND, 8'sh80,  VALUE_MIN,     1'b1, '{32'sd0,   7'd2, 1'b0, ST_DONE}},
        '{ACT_APPEND, 8'sd127, -32'sd1,       1'b1, '{32'sd0,   7'd3, 1'b0, ST_DONE}},
        '{ACT_APPEND, -8'sd1,  32'sd0,        1'b1, '{32'sd0,   7'd4, 1'b0, ST_DONE}},
        '{ACT_READ,   8'sh80,  32'sd0,        1'b1, '{VALUE_MAX, 7'd4, 1'b0, ST_DONE}},
        '{ACT_READ,   8'sd127, 32'sd0,        1'b1, '{32'sd0,   7'd4, 1'b0, ST_DONE}},
        '{ACT_READ,   8'sd1,   32'sd0,        1'b1, '{VALUE_MIN, 7'd4, 1'b0, ST_DONE}},
        '{ACT_WRITE,  -8'sd5,  32'sh1234_5678, 1'b0, '0},
        '{ACT_WRITE,  8'sd4,   32'sd11,       1'b1, '{32'sd0,   7'd4, 1'b0, ST_IGNORED}},
        '{ACT_WRITE,  8'sd2,   32'sh55AA_55AA, 1'b0, '0},
        '{ACT_REMOVE, 8'sd4,   32'sd0,        1'b1, '{32'sd0,   7'd4, 1'b0, ST_IGNORED}},
        '{ACT_REMOVE, -8'sd1,  32'sd0,        1'b1, '{32'sd0,   7'd4, 1'b0, ST_IGNORED}},
        '{ACT_REMOVE, 8'sd0,   32'sd0,        1'b0, '0},
        '{ACT_READ,   8'sd0,   32'sd0,        1'b0, '0},
        '{ACT_REMOVE, 8'sd2,   32'sd0,        1'b0, '0},
        '{ACT_RSVD_MID,  8'sd0, 32'sd0,       1'b1, '{32'sd0,   7'd2, 1'b0, ST_IGNORED}},
        '{ACT_RSVD_LAST, 8'sd1, 32'sd5,       1'b1, '{32'sd0,   7'd2, 1'b0, ST_IGNORED}},
        '{ACT_READ,   8'sd5,   32'sd0,        1'b0, '0},
        '{ACT_REMOVE, 8'sd1,   32'sd0,        1'b0, '0},
        '{ACT_CLEAR,  8'sd0,   32'sd0,        1'b1, '{32'sd0,   7'd0, 1'b1, ST_DONE}},
        '{ACT_READ,   -8'sd1,  32'sd0,        1'b1, '{EMPTY_READ_VALUE, 7'd0, 1'b1, ST_IGNORED}}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ils_req_if req_ch ();
    ils_rsp_if rsp_ch ();

    indexed_list_store #(
        .CAPACITY (LIST_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the list
    logic signed [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
    int                        shadow_len = 0;

    list_cmd_t    offered_words    [$];
    list_result_t expected_results [$];
    int           mismatch_count = 0;
    bit           holdoff_req    = 1'b0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one action to the shadow list and return the result word it gives
    function automatic list_result_t apply_list_action(
        input logic [ACTION_W-1:0]       act,
        input logic signed [POS_W-1:0]   pos,
        input logic signed [VALUE_W-1:0] val
    );
        list_result_t r;
        int           p;
        int           n;
        p = pos;
        n = shadow_len;
        r = '0;
        r.status = ST_DONE;
        case (act)
            ACT_APPEND:
            begin
                if (n < LIST_DEPTH)
                begin
                    shadow_entries[n] = val;
                    shadow_len = n + 1;
                end
                else
                    r.status = ST_FULL;
            end
            ACT_REMOVE:
            begin
                if (p >= 0 && p < n)
                begin
                    // close the gap
                    for (int i = p; i + 1 < n; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_len = n - 1;
                end
                else
                    r.status = ST_IGNORED;
            end
            ACT_READ:
            begin
                if (n == 0)
                begin
                    r.read_value = EMPTY_READ_VALUE;
                    r.status     = ST_IGNORED;
                end
                else if (p < 0)
                    r.read_value = shadow_entries[0];
                else if (p >= n)
                    r.read_value = shadow_entries[n - 1];
                else
                    r.read_value = shadow_entries[p];
            end
            ACT_WRITE:
            begin
                if (n == 0)
                    r.status = ST_IGNORED;
                else if (p < 0)
                    shadow_entries[0] = val;
                else if (p < n)
                    shadow_entries[p] = val;
                else
                    r.status = ST_IGNORED;
            end
            ACT_CLEAR:
                shadow_len = 0;
            default:
                r.status = ST_IGNORED;
        endcase
        r.entry_count = COUNT_OUT_W'(shadow_len);
        r.list_empty  = (shadow_len == 0);
        return r;
    endfunction

    // offer one request word from a falling edge until it is taken
    task automatic offer_word(input list_cmd_t cmd);
        offered_words.push_back(cmd);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= cmd.action;
        req_ch.position   <= cmd.position;
        req_ch.item_value <= cmd.item_value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // idle the request side for a number of cycles
    task automatic hold_idle(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        list_cmd_t    taken;
        list_result_t got;
        list_result_t want;
        list_result_t predicted;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.read_value, rsp_ch.entry_count, rsp_ch.list_empty,
                        rsp_ch.status};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result word: value %h count %0d empty %0d st %0d",
                                 $realtime, got.read_value, got.entry_count,
                                 got.list_empty, got.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_value !== want.read_value ||
                        got.entry_count !== want.entry_count ||
                        got.list_empty !== want.list_empty ||
                        got.status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected value %h count %0d empty %0d st %0d,",
                                     $realtime, want.read_value, want.entry_count,
                                     want.list_empty, want.status,
                                     " got value %h count %0d empty %0d st %0d",
                                     got.read_value, got.entry_count, got.list_empty,
                                     got.status);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                taken     = offered_words.pop_front();
                predicted = apply_list_action(req_ch.action, req_ch.position,
                                              req_ch.item_value);
                expected_results.push_back(taken.pinned ? taken.fixed : predicted);
            end
        end
    end

    // response side stalls: spans of always ready, random ready, and a fixed
    // pattern, plus one long hold-off on request from the sender
    initial
    begin
        int mode;
        int span;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (holdoff_req)
            begin
                repeat (HOLDOFF_CYCLES)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b0;
                end
                holdoff_req = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 60);
                for (int k = 0; k < span; k++)
                begin
                    @(negedge clk);
                    case (mode)
                        0:       rsp_ch.ready <= 1'b1;
                        1:       rsp_ch.ready <= ($urandom_range(0, 99) < 70);
                        2:       rsp_ch.ready <= ($urandom_range(0, 99) < 25);
                        default: rsp_ch.ready <= ((k % 4) != 3);
                    endcase
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial
    begin
        list_cmd_t      cmd;
        traffic_phase_t phase;
        int             burst_left;
        int             phase_left;
        int             roll;
        int             w_app;
        int             w_rem;
        int             w_rd;
        int             w_wr;
        int             w_clr;

        req_ch.valid      = 1'b0;
        req_ch.action     = '0;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        burst_left        = 0;
        phase_left        = 0;
        phase             = MIXED_PHASE;

        // reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < TOTAL_WORDS; n++)
        begin
            // bursts with random gaps, some bursts long and back to back
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    burst_left = $urandom_range(30, 80);
                else
                begin
                    hold_idle($urandom_range(0, 8));
                    burst_left = $urandom_range(1, 16);
                end
            end
            burst_left--;

            // long response hold-off while requests keep coming
            if (n == HOLDOFF_AT)
                holdoff_req = 1'b1;

            // let every outstanding result come back before going on
            if (n == DRAIN_AT)
            begin
                while (expected_results.size() != 0)
                begin
                    @(negedge clk);
                    req_ch.valid <= 1'b0;
                end
            end

            @(negedge clk);
            if (n < NUM_DIRECTED)
                cmd = DIRECTED_CMDS[n];
            else
            begin
                if (phase_left == 0)
                begin
                    roll = $urandom_range(0, 2);
                    phase = (roll == 0) ? FILL_PHASE : (roll == 1) ? DRAIN_PHASE : MIXED_PHASE;
                    phase_left = $urandom_range(40, 150);
                end
                phase_left--;

                case (phase)
                    FILL_PHASE:
                    begin
                        w_app = 82; w_rem = 3; w_rd = 8; w_wr = 6; w_clr = 0;
                    end
                    DRAIN_PHASE:
                    begin
                        w_app = 15; w_rem = 55; w_rd = 15; w_wr = 10; w_clr = 3;
                    end
                    default:
                    begin
                        w_app = 35; w_rem = 25; w_rd = 20; w_wr = 15; w_clr = 3;
                    end
                endcase

                cmd = '0;
                roll = $urandom_range(0, 99);
                if (roll < w_app)
                    cmd.action = ACT_APPEND;
                else if (roll < w_app + w_rem)
                    cmd.action = ACT_REMOVE;
                else if (roll < w_app + w_rem + w_rd)
                    cmd.action = ACT_READ;
                else if (roll < w_app + w_rem + w_rd + w_wr)
                    cmd.action = ACT_WRITE;
                else if (roll < w_app + w_rem + w_rd + w_wr + w_clr)
                    cmd.action = ACT_CLEAR;
                else
                    cmd.action = ACT_RSVD_FIRST + ACTION_W'($urandom_range(0, 2));

                // mostly live positions, some at the boundary, some anywhere
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    cmd.position = POS_W'($urandom_range(0, (shadow_len > 0) ? shadow_len - 1 : 0));
                else if (roll < 75)
                begin
                    case ($urandom_range(0, 2))
                        0:       cmd.position = -8'sd1;
                        1:       cmd.position = POS_W'(shadow_len);
                        default: cmd.position = POS_W'(shadow_len + 1);
                    endcase
                end
                else
                    cmd.position = POS_W'($urandom);

                case ($urandom_range(0, 9))
                    0:       cmd.item_value = VALUE_MAX;
                    1:       cmd.item_value = VALUE_MIN;
                    2:       cmd.item_value = '0;
                    3:       cmd.item_value = '1;
                    default: cmd.item_value = $urandom;
                endcase
            end
            offer_word(cmd);
        end

        // wind down
        hold_idle(1);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ils_pkg.sv
design/ils_req_if.sv
design/ils_rsp_if.sv
design/ils_ram.sv
design/indexed_list_store.sv
verif/tb_indexed_list_store.sv
